[rtl/scd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, scancode constants and character ROMs of the set-1 key decoder.
// ----------------------------------------------------------------------------
package scd_pkg;

	localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
	localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] NAV_LEFT     = 8'h4B;
	localparam logic [7:0] NAV_RIGHT    = 8'h4D;
	localparam logic [7:0] NAV_HOME     = 8'h47;
	localparam logic [7:0] NAV_END      = 8'h4F;
	localparam int unsigned BREAK_BIT   = 7;

	localparam logic [6:0] CH_NONE = 7'h00;
	localparam logic [6:0] CH_BKSP = 7'h08;
	localparam logic [6:0] CH_TAB  = 7'h09;
	localparam logic [6:0] CH_LF   = 7'h0A;
	localparam logic [6:0] CH_ESC  = 7'h1B;

	typedef enum logic [3:0] {
		KIND_PRINT = 4'd0,
		KIND_BKSP  = 4'd1,
		KIND_TAB   = 4'd2,
		KIND_ENTER = 4'd3,
		KIND_ESC   = 4'd4,
		KIND_LEFT  = 4'd5,
		KIND_RIGHT = 4'd6,
		KIND_HOME  = 4'd7,
		KIND_END   = 4'd8
	} key_kind_t;

	typedef struct packed {
		logic       emit;
		key_kind_t  kind;
		logic [6:0] char_code;
		logic       shift_nx;
		logic       prefix_nx;
	} scd_dec_t;

	function automatic logic [6:0] rom_plain(input logic [6:0] a);
		logic [6:0] c;
		unique case (a)
			7'h01: c = 7'h1B;
			7'h02: c = 7'h31;
			7'h03: c = 7'h32;
			7'h04: c = 7'h33;
			7'h05: c = 7'h34;
			7'h06: c = 7'h35;
			7'h07: c = 7'h36;
			7'h08: c = 7'h37;
			7'h09: c = 7'h38;
			7'h0A: c = 7'h39;
			7'h0B: c = 7'h30;
			7'h0C: c = 7'h2D;
			7'h0D: c = 7'h3D;
			7'h0E: c = 7'h08;
			7'h0F: c = 7'h09;
			7'h10: c = 7'h71;
			7'h11: c = 7'h77;
			7'h12: c = 7'h65;
			7'h13: c = 7'h72;
			7'h14: c = 7'h74;
			7'h15: c = 7'h79;
			7'h16: c = 7'h75;
			7'h17: c = 7'h69;
			7'h18: c = 7'h6F;
			7'h19: c = 7'h70;
			7'h1A: c = 7'h5B;
			7'h1B: c = 7'h5D;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h61;
			7'h1F: c = 7'h73;
			7'h20: c = 7'h64;
			7'h21: c = 7'h66;
			7'h22: c = 7'h67;
			7'h23: c = 7'h68;
			7'h24: c = 7'h6A;
			7'h25: c = 7'h6B;
			7'h26: c = 7'h6C;
			7'h27: c = 7'h3B;
			7'h28: c = 7'h27;
			7'h29: c = 7'h60;
			7'h2B: c = 7'h5C;
			7'h2C: c = 7'h7A;
			7'h2D: c = 7'h78;
			7'h2E: c = 7'h63;
			7'h2F: c = 7'h76;
			7'h30: c = 7'h62;
			7'h31: c = 7'h6E;
			7'h32: c = 7'h6D;
			7'h33: c = 7'h2C;
			7'h34: c = 7'h2E;
			7'h35: c = 7'h2F;
			7'h37: c = 7'h2A;
			7'h39: c = 7'h20;
			7'h47: c = 7'h37;
			7'h48: c = 7'h38;
			7'h49: c = 7'h39;
			7'h4A: c = 7'h2D;
			7'h4B: c = 7'h34;
			7'h4C: c = 7'h35;
			7'h4D: c = 7'h36;
			7'h4E: c = 7'h2B;
			7'h4F: c = 7'h31;
			7'h50: c = 7'h32;
			7'h51: c = 7'h33;
			7'h52: c = 7'h30;
			7'h53: c = 7'h2E;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

	// shifted codes that differ; all others match the plain table
	function automatic logic [6:0] rom_shift(input logic [6:0] a);
		logic [6:0] c;
		unique case (a)
			7'h02: c = 7'h21;
			7'h03: c = 7'h40;
			7'h04: c = 7'h23;
			7'h05: c = 7'h24;
			7'h06: c = 7'h25;
			7'h07: c = 7'h5E;
			7'h08: c = 7'h26;
			7'h09: c = 7'h2A;
			7'h0A: c = 7'h28;
			7'h0B: c = 7'h29;
			7'h0C: c = 7'h5F;
			7'h0D: c = 7'h2B;
			7'h10: c = 7'h51;
			7'h11: c = 7'h57;
			7'h12: c = 7'h45;
			7'h13: c = 7'h52;
			7'h14: c = 7'h54;
			7'h15: c = 7'h59;
			7'h16: c = 7'h55;
			7'h17: c = 7'h49;
			7'h18: c = 7'h4F;
			7'h19: c = 7'h50;
			7'h1A: c = 7'h7B;
			7'h1B: c = 7'h7D;
			7'h1E: c = 7'h41;
			7'h1F: c = 7'h53;
			7'h20: c = 7'h44;
			7'h21: c = 7'h46;
			7'h22: c = 7'h47;
			7'h23: c = 7'h48;
			7'h24: c = 7'h4A;
			7'h25: c = 7'h4B;
			7'h26: c = 7'h4C;
			7'h27: c = 7'h3A;
			7'h28: c = 7'h22;
			7'h29: c = 7'h7E;
			7'h2B: c = 7'h7C;
			7'h2C: c = 7'h5A;
			7'h2D: c = 7'h58;
			7'h2E: c = 7'h43;
			7'h2F: c = 7'h56;
			7'h30: c = 7'h42;
			7'h31: c = 7'h4E;
			7'h32: c = 7'h4D;
			7'h33: c = 7'h3C;
			7'h34: c = 7'h3E;
			7'h35: c = 7'h3F;
			default: c = rom_plain(a);
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/scd_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scd_decode
// Single-pass decode of one scancode byte against the shift and prefix flags.
// ----------------------------------------------------------------------------
module scd_decode (
	input  wire logic [7:0]       scan_byte,
	input  wire logic             shift_held,
	input  wire logic             prefix_seen,
	output scd_pkg::scd_dec_t     dec
);
	import scd_pkg::*;

	logic [6:0] rom_c;

	always_comb begin
		rom_c = shift_held ? rom_shift(scan_byte[6:0]) : rom_plain(scan_byte[6:0]);
	end

	always_comb begin
		dec           = '0;
		dec.kind      = KIND_PRINT;
		dec.shift_nx  = shift_held;
		dec.prefix_nx = prefix_seen;
		priority if (scan_byte == PREFIX_BYTE) begin
			dec.prefix_nx = 1'b1;
		end else if (prefix_seen) begin
			dec.prefix_nx = 1'b0;
			priority if (scan_byte == NAV_LEFT) begin
				dec.emit = 1'b1;
				dec.kind = KIND_LEFT;
			end else if (scan_byte == NAV_RIGHT) begin
				dec.emit = 1'b1;
				dec.kind = KIND_RIGHT;
			end else if (scan_byte == NAV_HOME) begin
				dec.emit = 1'b1;
				dec.kind = KIND_HOME;
			end else if (scan_byte == NAV_END) begin
				dec.emit = 1'b1;
				dec.kind = KIND_END;
			end else begin
				dec.emit = 1'b0;
			end
		end else if (scan_byte == LSHIFT_MAKE || scan_byte == RSHIFT_MAKE) begin
			dec.shift_nx = 1'b1;
		end else if (scan_byte == LSHIFT_BREAK || scan_byte == RSHIFT_BREAK) begin
			dec.shift_nx = 1'b0;
		end else if (scan_byte[BREAK_BIT]) begin
			dec.emit = 1'b0;
		end else begin
			dec.emit = (rom_c != CH_NONE);
			unique case (rom_c)
				CH_BKSP: dec.kind = KIND_BKSP;
				CH_TAB:  dec.kind = KIND_TAB;
				CH_LF:   dec.kind = KIND_ENTER;
				CH_ESC:  dec.kind = KIND_ESC;
				default: begin
					dec.kind      = KIND_PRINT;
					dec.char_code = rom_c;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/scancode_to_key_decoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_to_key_decoder_top
// Set-1 keyboard scancode to key decoder with valid/ready channels.
// Path: input register, then the single decode pass, then result register.
// Throughput: one byte per cycle, while no decoded key is held in the result
// register by a receiver that is not ready.
// Reset: asynchronous, clears shift and prefix flags and both valid bits.
// ----------------------------------------------------------------------------
module scancode_to_key_decoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] scan_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [3:0]      key_kind,
	output logic [6:0]      char_code
);
	import scd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       shift_q;
	logic       prefix_q;
	logic       out_valid_q;
	key_kind_t  kind_q;
	logic [6:0] char_q;
	scd_dec_t   dec;
	logic       s1_go;

	scd_decode u_decode (
		.scan_byte   (byte_s1),
		.shift_held  (shift_q),
		.prefix_seen (prefix_q),
		.dec         (dec)
	);

	assign s1_go    = valid_s1 && (!dec.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			shift_q     <= 1'b0;
			prefix_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_go) begin
				shift_q  <= dec.shift_nx;
				prefix_q <= dec.prefix_nx;
			end
			if (s1_go && dec.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= scan_byte;
		end
		if (s1_go && dec.emit) begin
			kind_q <= dec.kind;
			char_q <= dec.char_code;
		end
	end

	assign out_valid = out_valid_q;
	assign key_kind  = kind_q;
	assign char_code = char_q;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-1 scancode to key decoder. A short table of
// directed bytes covers reset state, control keys, shift handling and the
// extended prefix. Random typing-like byte streams follow: make and break
// codes, shift presses, prefixed navigation keys and raw noise. Every byte
// transfer runs through a local decoder model that queues the expected key;
// each key transfer is checked field by field against the oldest entry.
// Both channels idle in random bursts. One long receiver hold backs up the
// pipeline, and one sender pause lets it drain completely.
// ----------------------------------------------------------------------------
module tb_top;
	import scd_pkg::*;

	localparam int unsigned ITEM_TOTAL  = 950;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_LIMIT = 2000;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned HOLD_AT     = 300;
	localparam int unsigned PAUSE_AT    = 600;
	localparam int unsigned CALM_TAIL   = 150;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		logic       has;
		key_kind_t  kind;
		logic [6:0] ch;
	} scan_row_t;

	typedef struct packed {
		key_kind_t  kind;
		logic [6:0] ch;
	} key_exp_t;

	localparam int DIR_ROWS = 27;
	localparam scan_row_t DIR_TAB [DIR_ROWS] = '{
		'{8'h00, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'h1E, 1'b1, 1'b1, KIND_PRINT, 7'h61},
		'{8'h7F, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'h01, 1'b1, 1'b1, KIND_ESC,   7'h00},
		'{8'h0E, 1'b1, 1'b1, KIND_BKSP,  7'h00},
		'{8'h0F, 1'b1, 1'b1, KIND_TAB,   7'h00},
		'{8'h1C, 1'b1, 1'b1, KIND_ENTER, 7'h00},
		'{8'hFF, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'h2A, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'h1E, 1'b1, 1'b1, KIND_PRINT, 7'h41},
		'{8'h35, 1'b0, 1'b0, KIND_PRINT, 7'h00},
		'{8'hAA, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'hE0, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'hE0, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'h4B, 1'b1, 1'b1, KIND_LEFT,  7'h00},
		'{8'hE0, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'h4D, 1'b1, 1'b1, KIND_RIGHT, 7'h00},
		'{8'hE0, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'h47, 1'b1, 1'b1, KIND_HOME,  7'h00},
		'{8'hE0, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'h4F, 1'b1, 1'b1, KIND_END,   7'h00},
		'{8'h36, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'hE0, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'hB6, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'h1E, 1'b0, 1'b0, KIND_PRINT, 7'h00},
		'{8'hB6, 1'b1, 1'b0, KIND_PRINT, 7'h00},
		'{8'h4B, 1'b0, 1'b0, KIND_PRINT, 7'h00}
	};

	localparam logic [7:0] NAV_CODES [4]   = '{NAV_LEFT, NAV_RIGHT, NAV_HOME, NAV_END};
	localparam logic [7:0] SHIFT_CODES [4] =
		'{LSHIFT_MAKE, RSHIFT_MAKE, LSHIFT_BREAK, RSHIFT_BREAK};
	localparam int unsigned IDLE_MIX [4]   = '{0, 10, 35, 60};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] scan_byte = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [3:0] key_kind;
	logic [6:0] char_code;

	scan_row_t   byte_pin = '0;
	key_exp_t    key_exp_q [$];
	logic [6:0]  plain_tab [128];
	logic [6:0]  shift_tab [128];
	logic        shift_on    = 1'b0;
	logic        ext_pending = 1'b0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	bit          long_hold_req = 1'b0;
	int unsigned sent_cnt  = 0;
	int unsigned keys_out  = 0;
	int unsigned fail_cnt  = 0;
	int unsigned cycle_cnt = 0;
	int unsigned kind_cnt [9];

	always #4 clk = ~clk;

	scancode_to_key_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.scan_byte (scan_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_kind  (key_kind),
		.char_code (char_code)
	);

	function automatic void fill_run(input int base, input string lo, input string hi);
		for (int i = 0; i < lo.len(); i++) begin
			plain_tab[base + i] = 7'(lo[i]);
			shift_tab[base + i] = 7'(hi[i]);
		end
	endfunction

	task automatic decode_scan(input logic [7:0] b, output bit hit, output key_kind_t kind,
			output logic [6:0] ch);
		logic [6:0] c;
		hit  = 1'b0;
		kind = KIND_PRINT;
		ch   = CH_NONE;
		if (b == PREFIX_BYTE) begin
			ext_pending = 1'b1;
		end else if (ext_pending) begin
			ext_pending = 1'b0;
			hit = 1'b1;
			case (b)
				NAV_LEFT:  kind = KIND_LEFT;
				NAV_RIGHT: kind = KIND_RIGHT;
				NAV_HOME:  kind = KIND_HOME;
				NAV_END:   kind = KIND_END;
				default:   hit = 1'b0;
			endcase
		end else if (b == LSHIFT_MAKE || b == RSHIFT_MAKE) begin
			shift_on = 1'b1;
		end else if (b == LSHIFT_BREAK || b == RSHIFT_BREAK) begin
			shift_on = 1'b0;
		end else if (!b[BREAK_BIT]) begin
			c   = shift_on ? shift_tab[b[6:0]] : plain_tab[b[6:0]];
			hit = (c != CH_NONE);
			case (c)
				CH_BKSP: kind = KIND_BKSP;
				CH_TAB:  kind = KIND_TAB;
				CH_LF:   kind = KIND_ENTER;
				CH_ESC:  kind = KIND_ESC;
				default: ch = c;
			endcase
		end
	endtask

	always @(posedge clk) begin : key_check
		bit         hit;
		key_kind_t  kind;
		logic [6:0] ch;
		key_exp_t   want;
		if (arst_n && in_valid && in_ready) begin
			decode_scan(scan_byte, hit, kind, ch);
			if (byte_pin.typed) begin
				hit  = byte_pin.has;
				kind = byte_pin.kind;
				ch   = byte_pin.ch;
			end
			if (hit)
				key_exp_q.push_back(key_exp_t'{kind, ch});
		end
		if (arst_n && out_valid && out_ready) begin
			keys_out++;
			if (key_exp_q.size() == 0) begin
				$error("key transfer with nothing expected: key_kind %0d char_code %h",
					key_kind, char_code);
				fail_cnt++;
			end else begin
				want = key_exp_q.pop_front();
				kind_cnt[want.kind]++;
				if (key_kind !== want.kind) begin
					$error("key_kind: expected %0d, got %0d", want.kind, key_kind);
					fail_cnt++;
				end
				if (char_code !== want.ch) begin
					$error("char_code: expected %h, got %h", want.ch, char_code);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d keys outstanding", cycle_cnt,
				key_exp_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : rx_side
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && rx_idle_pct != 0 &&
					$urandom_range(99) < rx_idle_pct) begin
				stall_left = $urandom_range(19, 1);
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_scan(input scan_row_t r);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(19, 1)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		scan_byte <= r.b;
		byte_pin  <= r;
		sent_cnt++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_free(input logic [7:0] b);
		scan_row_t r;
		r   = '0;
		r.b = b;
		send_scan(r);
	endtask

	initial begin : stim
		int unsigned pick;
		int unsigned drain_cycles;
		bit          hold_done;
		bit          pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		for (int i = 0; i < 128; i++) begin
			plain_tab[i] = CH_NONE;
			shift_tab[i] = CH_NONE;
		end
		fill_run(8'h01, "\0331234567890-=\010\011", "\033!@#$%^&*()_+\010\011");
		fill_run(8'h10, "qwertyuiop[]\012", "QWERTYUIOP{}\012");
		fill_run(8'h1E, "asdfghjkl;'", "ASDFGHJKL:\"");
		plain_tab[8'h29] = 7'h60;
		shift_tab[8'h29] = 7'h7E;
		fill_run(8'h2B, "\\zxcvbnm,./", "|ZXCVBNM<>?");
		fill_run(8'h37, "*", "*");
		fill_run(8'h39, " ", " ");
		fill_run(8'h47, "789-456+1230.", "789-456+1230.");

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 20;
		rx_idle_pct = 20;
		for (int i = 0; i < DIR_ROWS; i++)
			send_scan(DIR_TAB[i]);

		while (sent_cnt < ITEM_TOTAL) begin
			if (sent_cnt >= ITEM_TOTAL - CALM_TAIL) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = IDLE_MIX[(sent_cnt / 80) % 4];
				rx_idle_pct = IDLE_MIX[(sent_cnt / 80 + 2) % 4];
			end
			// keep offering bytes while the receiver is held off
			if (sent_cnt >= HOLD_AT && sent_cnt < HOLD_AT + 60)
				tx_idle_pct = 0;
			if (!hold_done && sent_cnt >= HOLD_AT) begin
				long_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && sent_cnt >= PAUSE_AT) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (key_exp_q.size() != 0)
					@(negedge clk);
				@(posedge clk);
				pause_done = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_free(8'($urandom_range(8'h53)));
			end else if (pick < 55) begin
				send_free(8'h80 | 8'($urandom_range(8'h53)));
			end else if (pick < 65) begin
				send_free(SHIFT_CODES[$urandom_range(3)]);
			end else if (pick < 82) begin
				send_free(PREFIX_BYTE);
				if ($urandom_range(3) != 0)
					send_free(NAV_CODES[$urandom_range(3)]);
				else
					send_free(8'($urandom));
			end else begin
				send_free(8'($urandom));
			end
		end

		in_valid <= 1'b0;
		drain_cycles = 0;
		while (key_exp_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (8) @(posedge clk);
		if (key_exp_q.size() != 0) begin
			$error("%0d expected keys never arrived", key_exp_q.size());
			fail_cnt++;
		end

		$display("Run: %0d scancode bytes (%0d directed), %0d keys checked, %0d mismatches",
			sent_cnt, DIR_ROWS, keys_out, fail_cnt);
		$display("Keys: print %0d bksp %0d tab %0d enter %0d esc %0d ",
			kind_cnt[KIND_PRINT], kind_cnt[KIND_BKSP], kind_cnt[KIND_TAB],
			kind_cnt[KIND_ENTER], kind_cnt[KIND_ESC],
			"left %0d right %0d home %0d end %0d",
			kind_cnt[KIND_LEFT], kind_cnt[KIND_RIGHT], kind_cnt[KIND_HOME],
			kind_cnt[KIND_END]);
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
